FILE: sv/owb_pkg.sv
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types and constants for the one-wire bus master core: command and
// result words, configuration set, sequencer state and fixed slot timings.
// ----------------------------------------------------------------------------
package owb_pkg;

    localparam int TIMER_BITS    = 10;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 10;

    typedef logic [TIMER_BITS-1:0]    timer_t;
    typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

    // command codes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // register indexes
    localparam cfg_idx_t REG_RESET_LOW_TIME    = 3'd0;
    localparam cfg_idx_t REG_PRESENCE_DELAY    = 3'd1;
    localparam cfg_idx_t REG_PRESENCE_TIMEOUT  = 3'd2;
    localparam cfg_idx_t REG_RESET_RECOVERY    = 3'd3;
    localparam cfg_idx_t REG_WRITE_START_LOW   = 3'd4;
    localparam cfg_idx_t REG_WRITE_ONE_HIGH    = 3'd5;
    localparam cfg_idx_t REG_WRITE_ZERO_LOW    = 3'd6;
    localparam cfg_idx_t REG_READ_SAMPLE_DELAY = 3'd7;

    // register reset values
    localparam logic [9:0] RESET_LOW_TIME_INIT    = 10'd600;
    localparam logic [7:0] PRESENCE_DELAY_INIT    = 8'd20;
    localparam logic [9:0] PRESENCE_TIMEOUT_INIT  = 10'd200;
    localparam logic [9:0] RESET_RECOVERY_INIT    = 10'd240;
    localparam logic [7:0] WRITE_START_LOW_INIT   = 8'd8;
    localparam logic [7:0] WRITE_ONE_HIGH_INIT    = 8'd58;
    localparam logic [7:0] WRITE_ZERO_LOW_INIT    = 8'd60;
    localparam logic [7:0] READ_SAMPLE_DELAY_INIT = 8'd12;

    // fixed slot timings
    localparam timer_t ZERO_TAIL_T = timer_t'(2);
    localparam timer_t RD_LOW_T    = timer_t'(5);
    localparam timer_t RD_TAIL_T   = timer_t'(45);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_POLL,
        PH_RECOVER,
        PH_WR_START,
        PH_WR_ONE,
        PH_WR_ZLOW,
        PH_WR_ZREL,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_TAIL
    } phase_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] write_byte;
        logic       line_in;
    } cmd_t;

    typedef struct packed {
        logic       pull_low;
        logic       busy_res;
        logic       done_res;
        logic       present;
        logic [7:0] read_data;
    } res_t;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] presence_delay;
        logic [9:0] presence_timeout;
        logic [9:0] reset_recovery;
        logic [7:0] write_start_low;
        logic [7:0] write_one_high;
        logic [7:0] write_zero_low;
        logic [7:0] read_sample_delay;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        timer_t     tick_timer;
        logic [2:0] bit_index;
        logic [7:0] shift_byte;
        logic       presence_seen;
    } owb_state_t;

endpackage

FILE: sv/owb_cfg_regs.sv
// ----------------------------------------------------------------------------
// owb_cfg_regs
// Timing register file. One write per cycle, values truncated to the field.
// ----------------------------------------------------------------------------
module owb_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  owb_pkg::cfg_idx_t  wr_index,
    input  owb_pkg::cfg_data_t wr_data,
    output owb_pkg::cfg_t      cfg
);
    import owb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_RESET_LOW_TIME:    cfg_next.reset_low_time    = wr_data[9:0];
                REG_PRESENCE_DELAY:    cfg_next.presence_delay    = wr_data[7:0];
                REG_PRESENCE_TIMEOUT:  cfg_next.presence_timeout  = wr_data[9:0];
                REG_RESET_RECOVERY:    cfg_next.reset_recovery    = wr_data[9:0];
                REG_WRITE_START_LOW:   cfg_next.write_start_low   = wr_data[7:0];
                REG_WRITE_ONE_HIGH:    cfg_next.write_one_high    = wr_data[7:0];
                REG_WRITE_ZERO_LOW:    cfg_next.write_zero_low    = wr_data[7:0];
                REG_READ_SAMPLE_DELAY: cfg_next.read_sample_delay = wr_data[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time    <= RESET_LOW_TIME_INIT;
            cfg_reg.presence_delay    <= PRESENCE_DELAY_INIT;
            cfg_reg.presence_timeout  <= PRESENCE_TIMEOUT_INIT;
            cfg_reg.reset_recovery    <= RESET_RECOVERY_INIT;
            cfg_reg.write_start_low   <= WRITE_START_LOW_INIT;
            cfg_reg.write_one_high    <= WRITE_ONE_HIGH_INIT;
            cfg_reg.write_zero_low    <= WRITE_ZERO_LOW_INIT;
            cfg_reg.read_sample_delay <= READ_SAMPLE_DELAY_INIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/owb_tick.sv
// ----------------------------------------------------------------------------
// owb_tick
// Next-state and result logic for one bus tick: command start, the tick
// itself, and skipping of phases whose time is used up (zero-length ones).
// ----------------------------------------------------------------------------
module owb_tick (
    input  owb_pkg::cfg_t       cfg,
    input  owb_pkg::owb_state_t st,
    input  owb_pkg::cmd_t       cmd,
    output owb_pkg::owb_state_t st_next,
    output owb_pkg::res_t       res
);
    import owb_pkg::*;

    function automatic owb_state_t go_idle(owb_state_t s);
        s.phase      = PH_IDLE;
        s.tick_timer = '0;
        return s;
    endfunction

    function automatic owb_state_t poll_entry(owb_state_t s, cfg_t c);
        s.phase      = PH_POLL;
        s.tick_timer = '0;
        if (timer_t'(c.presence_timeout) == '0)
        begin
            s.presence_seen = 1'b0;
            s = go_idle(s);
        end
        return s;
    endfunction

    function automatic owb_state_t rst_wait_entry(owb_state_t s, cfg_t c);
        s.phase      = PH_RST_WAIT;
        s.tick_timer = '0;
        if (timer_t'(c.presence_delay) == '0)
            s = poll_entry(s, c);
        return s;
    endfunction

    function automatic owb_state_t recover_entry(owb_state_t s, cfg_t c);
        s.phase      = PH_RECOVER;
        s.tick_timer = '0;
        if (timer_t'(c.reset_recovery) == '0)
            s = go_idle(s);
        return s;
    endfunction

    function automatic owb_state_t zlow_entry(owb_state_t s, cfg_t c);
        s.tick_timer = '0;
        s.phase      = (c.write_zero_low != '0) ? PH_WR_ZLOW : PH_WR_ZREL;
        return s;
    endfunction

    function automatic owb_state_t rd_wait_entry(owb_state_t s, cfg_t c);
        s.tick_timer = '0;
        s.phase      = (c.read_sample_delay != '0) ? PH_RD_WAIT : PH_RD_TAIL;
        return s;
    endfunction

    // Bit body after the start low. With no start low and no one-high time,
    // one bits cost nothing: jump straight to the first bit that takes time.
    function automatic owb_state_t wr_body(owb_state_t s, cfg_t c);
        logic       loop_on;
        logic [3:0] lim;
        logic       found;
        logic [2:0] k_sel;
        loop_on = (c.write_start_low == '0);
        lim     = loop_on ? {1'b0, 3'd7 - s.bit_index} : 4'd0;
        found   = 1'b0;
        k_sel   = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (4'(k) <= lim && (!s.shift_byte[k] || c.write_one_high != '0))
            begin
                found = 1'b1;
                k_sel = 3'(k);
            end
        end
        s.tick_timer = '0;
        if (found)
        begin
            s.bit_index  = s.bit_index + k_sel;
            s.shift_byte = s.shift_byte >> k_sel;
            if (s.shift_byte[0])
                s.phase = PH_WR_ONE;
            else
                s = zlow_entry(s, c);
        end
        else if (loop_on || s.bit_index == 3'd7)
        begin
            s = go_idle(s);
        end
        else
        begin
            s.bit_index  = s.bit_index + 3'd1;
            s.shift_byte = s.shift_byte >> 1;
            s.phase      = PH_WR_START;
        end
        return s;
    endfunction

    function automatic owb_state_t wr_entry(owb_state_t s, cfg_t c);
        s.tick_timer = '0;
        if (c.write_start_low != '0)
            s.phase = PH_WR_START;
        else
            s = wr_body(s, c);
        return s;
    endfunction

    function automatic owb_state_t wr_next_bit(owb_state_t s, cfg_t c);
        s.shift_byte = s.shift_byte >> 1;
        if (s.bit_index == 3'd7)
        begin
            s = go_idle(s);
        end
        else
        begin
            s.bit_index = s.bit_index + 3'd1;
            s = wr_entry(s, c);
        end
        return s;
    endfunction

    function automatic owb_state_t rd_next_bit(owb_state_t s);
        s.tick_timer = '0;
        if (s.bit_index == 3'd7)
        begin
            s.phase = PH_IDLE;
        end
        else
        begin
            s.bit_index = s.bit_index + 3'd1;
            s.phase     = PH_RD_LOW;
        end
        return s;
    endfunction

    // leave the current phase if its time is spent
    function automatic owb_state_t settle(owb_state_t s, cfg_t c);
        owb_state_t r;
        r = s;
        unique case (s.phase)
            PH_RST_LOW:
                if (s.tick_timer >= timer_t'(c.reset_low_time)) r = rst_wait_entry(s, c);
            PH_RST_WAIT:
                if (s.tick_timer >= timer_t'(c.presence_delay)) r = poll_entry(s, c);
            PH_POLL:
                if (s.tick_timer >= timer_t'(c.presence_timeout))
                begin
                    r.presence_seen = 1'b0;
                    r = go_idle(r);
                end
            PH_RECOVER:
                if (s.tick_timer >= timer_t'(c.reset_recovery)) r = go_idle(s);
            PH_WR_START:
                if (s.tick_timer >= timer_t'(c.write_start_low)) r = wr_body(s, c);
            PH_WR_ONE:
                if (s.tick_timer >= timer_t'(c.write_one_high)) r = wr_next_bit(s, c);
            PH_WR_ZLOW:
                if (s.tick_timer >= timer_t'(c.write_zero_low))
                begin
                    r.tick_timer = '0;
                    r.phase      = PH_WR_ZREL;
                end
            PH_WR_ZREL:
                if (s.tick_timer >= ZERO_TAIL_T) r = wr_next_bit(s, c);
            PH_RD_LOW:
                if (s.tick_timer >= RD_LOW_T) r = rd_wait_entry(s, c);
            PH_RD_WAIT:
                if (s.tick_timer >= timer_t'(c.read_sample_delay))
                begin
                    r.tick_timer = '0;
                    r.phase      = PH_RD_TAIL;
                end
            PH_RD_TAIL:
                if (s.tick_timer >= RD_TAIL_T) r = rd_next_bit(s);
            default: r = s;
        endcase
        return r;
    endfunction

    owb_state_t s_start;
    owb_state_t s_tick;
    logic       active;
    logic       reading;
    logic       pull;
    logic       done;

    always_comb
    begin
        // command start
        s_start = st;
        if (st.phase == PH_IDLE && cmd.mode != MODE_NONE)
        begin
            s_start.tick_timer = '0;
            s_start.bit_index  = 3'd0;
            unique case (cmd.mode)
                MODE_RESET:
                begin
                    s_start.phase         = PH_RST_LOW;
                    s_start.presence_seen = 1'b0;
                end
                MODE_WRITE:
                begin
                    s_start.phase      = PH_WR_START;
                    s_start.shift_byte = cmd.write_byte;
                end
                MODE_READ:
                begin
                    s_start.phase      = PH_RD_LOW;
                    s_start.shift_byte = 8'd0;
                end
                default: s_start.phase = PH_IDLE;
            endcase
            s_start = settle(s_start, cfg);
        end

        active  = (st.phase != PH_IDLE) || (cmd.mode != MODE_NONE);
        reading = (s_start.phase == PH_RD_LOW) || (s_start.phase == PH_RD_WAIT) ||
                  (s_start.phase == PH_RD_TAIL);

        // the tick itself
        s_tick = s_start;
        pull   = 1'b0;
        if (s_start.phase != PH_IDLE)
        begin
            pull = (s_start.phase == PH_RST_LOW) || (s_start.phase == PH_WR_START) ||
                   (s_start.phase == PH_WR_ZLOW) || (s_start.phase == PH_RD_LOW);
            if (s_start.phase == PH_POLL && !cmd.line_in)
            begin
                s_tick.presence_seen = 1'b1;
                s_tick = recover_entry(s_tick, cfg);
            end
            else
            begin
                if (s_start.phase == PH_RD_TAIL && s_start.tick_timer == '0)
                    s_tick.shift_byte = {cmd.line_in, s_start.shift_byte[7:1]};
                s_tick.tick_timer = s_start.tick_timer + timer_t'(1);
                s_tick = settle(s_tick, cfg);
            end
        end

        done = active && (s_tick.phase == PH_IDLE);

        st_next       = s_tick;
        res.pull_low  = pull;
        res.busy_res  = active;
        res.done_res  = done;
        res.present   = s_tick.presence_seen;
        res.read_data = (done && reading) ? s_tick.shift_byte : 8'd0;
    end

endmodule

FILE: sv/one_wire_bus_master_core.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_core
// One-wire bus master sequencer: reset/presence, byte write, byte read.
// ----------------------------------------------------------------------------
// Each command word is one bus tick (normally 1 us) carrying the sampled
// line level and, when the master is idle, a command: bus reset, write a
// byte or read a byte, LSB first. The block only ever pulls the line low or
// releases it (pull_low). Every command word returns exactly one result
// word. Throughput is one word per clock while cmd_stall stays low; a word
// is held in the input register and its result is registered in the output
// register. The rate is set by the single sequencer state register that
// every tick reads and rewrites. The result register decouples the two
// sides: a new word is still taken while an earlier result waits, and
// cmd_stall rises only when both the input and result registers are full
// and the result side stalls. Timing registers sit on a separate write
// port (cfg_ready is always high) and must only be written while no
// command is running. A timing of zero skips its phase in the same tick;
// a zero presence timeout reports absent without sampling.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core (
    input  logic               clk,
    input  logic               rst_n,
    // command words
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  owb_pkg::cmd_t      cmd,
    // result words
    output logic               res_valid,
    input  logic               res_stall,
    output owb_pkg::res_t      res,
    // timing register writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  owb_pkg::cfg_idx_t  cfg_index,
    input  owb_pkg::cfg_data_t cfg_data
);
    import owb_pkg::*;

    cfg_t       cfg;

    // input register
    cmd_t       cmd_reg;
    logic       cmd_vld_reg;
    logic       cmd_vld_next;

    // sequencer state
    owb_state_t state_reg;
    owb_state_t state_next;

    // result register
    res_t       res_reg;
    res_t       res_word;
    logic       res_vld_reg;
    logic       res_vld_next;

    logic       cmd_take;
    logic       advance;

    assign cfg_ready = 1'b1;

    owb_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    owb_tick u_tick (
        .cfg     (cfg),
        .st      (state_reg),
        .cmd     (cmd_reg),
        .st_next (state_next),
        .res     (res_word)
    );

    // a held word moves on when the result slot is free or being drained
    assign advance   = cmd_vld_reg && (!res_vld_reg || !res_stall);
    assign cmd_stall = cmd_vld_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    always_comb
    begin
        cmd_vld_next = cmd_vld_reg;
        if (cmd_take)
            cmd_vld_next = 1'b1;
        else if (advance)
            cmd_vld_next = 1'b0;

        res_vld_next = res_vld_reg;
        if (advance)
            res_vld_next = 1'b1;
        else if (!res_stall)
            res_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg             <= 1'b0;
            res_vld_reg             <= 1'b0;
            state_reg.phase         <= PH_IDLE;
            state_reg.tick_timer    <= '0;
            state_reg.bit_index     <= '0;
            state_reg.shift_byte    <= '0;
            state_reg.presence_seen <= 1'b0;
        end
        else
        begin
            cmd_vld_reg <= cmd_vld_next;
            res_vld_reg <= res_vld_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_take)
            cmd_reg <= cmd;
        if (advance)
            res_reg <= res_word;
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    // line is only pulled while a command runs
    a_pull_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.pull_low) |-> res.busy_res)
        else $error("pull_low outside a command");

    // read data only on a done word
    a_rdata_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.read_data != 8'd0) |-> res.done_res)
        else $error("read_data nonzero outside done");

    // input stalls only when both stages are full and the result is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (cmd_vld_reg && res_valid && res_stall))
        else $error("cmd_stall without a full pipeline");

endmodule
